// ----- sv/fcfs_pkg.sv -----
// ----------------------------------------------------------------------------
// FCFS scheduler package
// Shared types and constants for the FCFS CPU and resource scheduler.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clear;       // return to reset state
        logic load;        // store one burst
        logic zero;        // no-op item: cpu, resource, time and error fields read zero
        logic scan;        // examine process r_scan_idx for arrival
        logic pend;        // move pending jobs into queues
        logic run_cpu;     // run ready queue head
        logic rd_res;      // fetch remaining length of resource queue head
        logic run_res;     // run resource queue head
        logic fin;         // advance time, form result
        logic done_chk;    // examine process r_scan_idx for completion
        logic done_start;  // start completion scan
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic done_last;
    } t_sts;

endpackage

// ----- sv/fcfs_dp.sv -----
// ----------------------------------------------------------------------------
// FCFS datapath
// Process tables, two job FIFOs, arrival and completion scans.
// ----------------------------------------------------------------------------
module fcfs_dp import fcfs_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int MAX_BURSTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_name,
    input  logic [15:0] i_arrival,
    input  logic [7:0]  i_len,
    input  logic        i_last,
    output logic [7:0]  o_cpu,
    output logic [7:0]  o_res,
    output logic        o_all_done,
    output logic        o_load_error,
    output logic [15:0] o_time
);
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int BW = (MAX_BURSTS > 1) ? $clog2(MAX_BURSTS) : 1;
    localparam int CW = $clog2(MAX_BURSTS + 1);
    localparam int NW = $clog2(MAX_PROCS + 1);
    localparam int QD = 1 << PW;
    localparam int RW = PW + BW;
    localparam int RD = 1 << RW;
    localparam logic [NW-1:0] NPROC = NW'(MAX_PROCS);
    localparam logic [CW-1:0] NBURST = CW'(MAX_BURSTS);

    logic [CW-1:0] r_bcnt  [MAX_PROCS];
    logic [CW-1:0] r_bpos  [MAX_PROCS];
    logic [15:0]   r_arr   [MAX_PROCS];
    logic [7:0]    r_nm    [MAX_PROCS];
    logic [PW-1:0] r_rq    [QD];
    logic [PW-1:0] r_sq    [QD];
    logic [7:0]    r_rem_mem [RD];
    logic [7:0]    r_rem_q;
    logic [PW-1:0] r_rq_hd, r_sq_hd;
    logic [NW-1:0] r_rq_n, r_sq_n;
    logic          r_pr_v, r_pd_v;
    logic [PW-1:0] r_pr_i, r_pd_i;
    logic [15:0]   r_tick;
    logic          r_ended;
    logic [NW-1:0] r_loaded;
    logic          r_open;
    logic [PW-1:0] r_scan_idx;
    logic          r_done_acc;
    logic [7:0]    r_cpu, r_res;
    logic          r_err, r_all_done;
    logic [15:0]   r_time;

    logic [NW-1:0] w_last_scan;
    logic [PW-1:0] w_cur;
    logic [7:0]    w_len;
    logic [PW-1:0] w_rp, w_sp;
    logic          w_new_ok, w_add_ok;
    logic          w_run, w_side;
    logic [PW-1:0] w_hp;
    logic [CW-1:0] w_hpos;
    logic [NW-1:0] w_hq_n;
    logic          w_hstop, w_hlast, w_more;
    logic          w_rem_we;
    logic [RW-1:0] w_rem_waddr, w_rem_raddr;
    logic [7:0]    w_rem_wdata;

    assign w_last_scan = (r_loaded == '0) ? '0 : r_loaded - 1'b1;
    assign o_sts.scan_last = (NW'(r_scan_idx) >= w_last_scan) || (r_loaded == '0);
    assign o_sts.done_last = o_sts.scan_last;
    assign w_cur = PW'(r_loaded - 1'b1);
    assign w_len = (i_len == 8'd0) ? 8'd1 : i_len;
    assign w_rp = r_rq[r_rq_hd];
    assign w_sp = r_sq[r_sq_hd];

    assign w_new_ok = !r_open && (r_loaded < NPROC);
    assign w_add_ok = r_open && (r_bcnt[w_cur] < NBURST);

    // queue head being worked on; the length store is read in the cycle before its use
    assign w_run   = i_cmd.run_cpu | i_cmd.run_res;
    assign w_side  = i_cmd.rd_res | i_cmd.run_res;
    assign w_hp    = w_side ? w_sp : w_rp;
    assign w_hq_n  = w_side ? r_sq_n : r_rq_n;
    assign w_hpos  = r_bpos[w_hp];
    assign w_hstop = (w_hpos >= NBURST) || (w_hpos >= r_bcnt[w_hp]);
    assign w_hlast = (r_rem_q <= 8'd1);
    assign w_more  = (w_hpos + 1'b1) < r_bcnt[w_hp];
    assign w_rem_raddr = {w_hp, BW'(w_hpos)};

    always_comb begin
        w_rem_we    = 1'b0;
        w_rem_waddr = w_rem_raddr;
        w_rem_wdata = w_hlast ? 8'd0 : r_rem_q - 8'd1;
        if (i_cmd.load) begin
            w_rem_we    = w_new_ok || w_add_ok;
            w_rem_waddr = w_new_ok ? {PW'(r_loaded), {BW{1'b0}}} :
                                     {w_cur, BW'(r_bcnt[w_cur])};
            w_rem_wdata = w_len;
        end else if (w_run && w_hq_n != '0 && !w_hstop) begin
            w_rem_we = 1'b1;
        end
        if (!i_rst_n || i_cmd.clear) begin
            w_rem_we = 1'b0;
        end
    end

    // remaining burst lengths, registered read
    always_ff @(posedge i_clk) begin
        if (w_rem_we) begin
            r_rem_mem[w_rem_waddr] <= w_rem_wdata;
        end
        r_rem_q <= r_rem_mem[w_rem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int p = 0; p < MAX_PROCS; p++) begin
                r_bcnt[p] <= '0;
                r_bpos[p] <= '0;
            end
            r_rq_hd <= '0; r_sq_hd <= '0; r_rq_n <= '0; r_sq_n <= '0;
            r_pr_v <= 1'b0; r_pd_v <= 1'b0;
            r_tick <= '0; r_ended <= 1'b0; r_loaded <= '0; r_open <= 1'b0;
            r_scan_idx <= '0; r_done_acc <= 1'b1;
            r_cpu <= '0; r_res <= '0; r_err <= 1'b0; r_all_done <= 1'b1;
            r_time <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cpu <= '0; r_res <= '0; r_time <= '0;
                r_err <= !(w_new_ok || w_add_ok);
                if (w_new_ok) begin
                    r_nm[PW'(r_loaded)]   <= i_name;
                    r_arr[PW'(r_loaded)]  <= i_arrival;
                    r_bpos[PW'(r_loaded)] <= '0;
                    r_bcnt[PW'(r_loaded)] <= CW'(1);
                    r_loaded <= r_loaded + 1'b1;
                    r_open <= !i_last;
                end else if (r_open) begin
                    // last mark closes the process even when the burst is dropped
                    r_open <= !i_last;
                    if (w_add_ok) begin
                        r_bcnt[w_cur] <= r_bcnt[w_cur] + 1'b1;
                    end
                end
            end
            if (i_cmd.zero) begin
                r_cpu <= '0; r_res <= '0; r_time <= '0; r_err <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (!r_ended && r_loaded != '0 && r_arr[r_scan_idx] == r_tick &&
                    r_rq_n < NPROC) begin
                    r_rq[PW'(r_rq_hd + PW'(r_rq_n))] <= r_scan_idx;
                    r_rq_n <= r_rq_n + 1'b1;
                end
                r_scan_idx <= o_sts.scan_last ? '0 : r_scan_idx + 1'b1;
            end
            if (i_cmd.pend) begin
                if (r_pr_v && r_sq_n < NPROC) begin
                    r_sq[PW'(r_sq_hd + PW'(r_sq_n))] <= r_pr_i;
                    r_sq_n <= r_sq_n + 1'b1;
                end
                if (r_pd_v && r_rq_n < NPROC) begin
                    r_rq[PW'(r_rq_hd + PW'(r_rq_n))] <= r_pd_i;
                    r_rq_n <= r_rq_n + 1'b1;
                end
                r_pr_v <= 1'b0; r_pd_v <= 1'b0;
            end
            if (i_cmd.run_cpu) begin
                r_cpu <= (r_rq_n != '0) ? r_nm[w_rp] : '0;
                if (r_rq_n != '0 && (w_hstop || w_hlast)) begin
                    r_rq_hd <= r_rq_hd + 1'b1; r_rq_n <= r_rq_n - 1'b1;
                end
                if (r_rq_n != '0 && !w_hstop && w_hlast && w_more) begin
                    r_pr_v <= 1'b1; r_pr_i <= w_rp;
                end
            end
            if (i_cmd.run_res) begin
                r_res <= (r_sq_n != '0) ? r_nm[w_sp] : '0;
                if (r_sq_n != '0 && (w_hstop || w_hlast)) begin
                    r_sq_hd <= r_sq_hd + 1'b1; r_sq_n <= r_sq_n - 1'b1;
                end
                if (r_sq_n != '0 && !w_hstop && w_hlast && w_more) begin
                    r_pd_v <= 1'b1; r_pd_i <= w_sp;
                end
            end
            if (w_run && w_hq_n != '0 && !w_hstop && w_hlast) begin
                r_bpos[w_hp] <= w_hpos + 1'b1;
            end
            if (i_cmd.fin) begin
                r_err <= 1'b0;
                r_time <= r_tick;
                if (r_tick == 16'hFFFF) r_ended <= 1'b1;
                else r_tick <= r_tick + 1'b1;
            end
            if (i_cmd.done_start) begin
                r_scan_idx <= '0;
                r_done_acc <= 1'b1;
            end
            if (i_cmd.done_chk) begin
                if (r_loaded != '0 && r_bpos[r_scan_idx] < r_bcnt[r_scan_idx])
                    r_done_acc <= 1'b0;
                if (o_sts.done_last) begin
                    r_all_done <= r_done_acc &&
                        !(r_loaded != '0 && r_bpos[r_scan_idx] < r_bcnt[r_scan_idx]);
                    r_scan_idx <= '0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
        end
    end

    assign o_cpu = r_cpu;
    assign o_res = r_res;
    assign o_all_done = r_all_done;
    assign o_load_error = r_err;
    assign o_time = r_time;
endmodule

// ----- sv/fcfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// FCFS controller
// Sequences one item: load or tick, then completion scan and output; clear or an unused code goes straight to output.
// ----------------------------------------------------------------------------
module fcfs_ctrl import fcfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cmd       o_cmd,
    input  t_sts       i_sts
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_PEND = 9'b000000100,
        S_RDC  = 9'b000001000,
        S_RUNC = 9'b000010000,
        S_RDR  = 9'b000100000,
        S_RUNR = 9'b001000000,
        S_DONE = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   w_take;

    assign o_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_valid = (r_state == S_OUT);
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    case (i_action)
                        ACT_LOAD:  begin o_cmd.load = 1'b1; n_state = S_DONE; end
                        ACT_TICK:  n_state = S_SCAN;
                        ACT_CLEAR: begin o_cmd.clear = 1'b1; n_state = S_OUT; end
                        default:   begin o_cmd.zero = 1'b1; n_state = S_OUT; end
                    endcase
                    o_cmd.done_start = (i_action != ACT_CLEAR);
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_PEND;
            end
            S_PEND: begin o_cmd.pend = 1'b1; n_state = S_RDC; end
            // length store read for the ready head is in flight
            S_RDC:  n_state = S_RUNC;
            S_RUNC: begin o_cmd.run_cpu = 1'b1; n_state = S_RDR; end
            S_RDR:  begin o_cmd.rd_res = 1'b1; n_state = S_RUNR; end
            S_RUNR: begin
                o_cmd.run_res = 1'b1; o_cmd.fin = 1'b1;
                o_cmd.done_start = 1'b1; n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done_chk = 1'b1;
                if (i_sts.done_last) n_state = S_OUT;
            end
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ----- sv/fcfs_cpu_and_resource_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// FCFS CPU and resource scheduler
// One CPU and one shared resource served first come first served.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata = {last_burst, burst_length, arrival_time,
// process_name, action} from bit 0. action 0 loads one burst, 1 advances one
// tick, 2 clears everything. Every transfer yields one result on m_axis:
// tdata = {current_time, load_error, all_done, resource_process, cpu_process}.
// A clear or unused code yields its result directly, a load after a completion
// scan over the loaded processes, and a tick after an arrival scan, pending
// moves, a read and a run step for each queue head and a completion scan. One
// item at a time: the next input is taken only after the result transfer.
// The result is held until m_axis_tready; no input is taken while it waits.
// Reset clears all processes, queues and time; all_done reads 1 afterwards.
// ----------------------------------------------------------------------------
module fcfs_cpu_and_resource_scheduler_top import fcfs_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int MAX_BURSTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], process_name[9:2], arrival_time[25:10],
    // burst_length[33:26], last_burst[34], zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cpu_process[7:0], resource_process[15:8], all_done[16],
    // load_error[17], current_time[33:18], zero fill
    output logic [39:0] m_axis_tdata
);
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [7:0]  w_cpu, w_res;
    logic        w_done, w_err;
    logic [15:0] w_time;

    fcfs_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid (s_axis_tvalid),
        .i_action(s_axis_tdata[1:0]),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    fcfs_dp #(.MAX_PROCS(MAX_PROCS), .MAX_BURSTS(MAX_BURSTS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_name      (s_axis_tdata[9:2]),
        .i_arrival   (s_axis_tdata[25:10]),
        .i_len       (s_axis_tdata[33:26]),
        .i_last      (s_axis_tdata[34]),
        .o_cpu       (w_cpu),
        .o_res       (w_res),
        .o_all_done  (w_done),
        .o_load_error(w_err),
        .o_time      (w_time)
    );

    assign m_axis_tdata = {6'd0, w_time, w_err, w_done, w_res, w_cpu};
endmodule

// ----- tb/fcfs_scheduler_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FCFS scheduler checker
// Watches both stream channels, keeps its own copy of the process table and
// the two queues, predicts one result per input transfer and compares it
// field by field with the result transfers in order.
// ----------------------------------------------------------------------------
module fcfs_scheduler_checker import fcfs_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int MAX_BURSTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // action, name, arrival, length, last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // cpu, resource, all_done, error, time
    output int          o_errors,
    output int          o_outstanding
);

    typedef struct packed {
        logic [15:0] now;
        logic        err;
        logic        done;
        logic [7:0]  res;
        logic [7:0]  cpu;
    } t_sched_result;

    logic [7:0]  left_ticks [MAX_PROCS][MAX_BURSTS];
    int          nbursts    [MAX_PROCS];
    logic [15:0] arrive_at  [MAX_PROCS];
    logic [7:0]  proc_name  [MAX_PROCS];
    int          cur_burst  [MAX_PROCS];
    int          cpu_q[$];
    int          res_q[$];
    logic        to_res_v, to_rdy_v;
    int          to_res_p, to_rdy_p;
    logic [15:0] tick_now;
    int          nprocs;
    logic        open_proc, time_over;
    int          err_count = 0;
    t_sched_result expected_results[$];

    function automatic void clear_table();
        for (int p = 0; p < MAX_PROCS; p++) begin
            nbursts[p]   = 0;
            cur_burst[p] = 0;
        end
        cpu_q.delete();
        res_q.delete();
        to_res_v  = 0;
        to_rdy_v  = 0;
        tick_now  = '0;
        nprocs    = 0;
        open_proc = 0;
        time_over = 0;
    endfunction

    function automatic logic store_burst(logic [39:0] d);
        logic [7:0] len;
        int p;
        len = d[33:26];
        if (len == 0) len = 8'd1;
        if (!open_proc) begin
            if (nprocs >= MAX_PROCS) return 1'b1;
            p = nprocs;
            proc_name[p]     = d[9:2];
            arrive_at[p]     = d[25:10];
            cur_burst[p]     = 0;
            nbursts[p]       = 1;
            left_ticks[p][0] = len;
            nprocs++;
            open_proc = !d[34];
            return 1'b0;
        end
        p = nprocs - 1;
        if (d[34]) open_proc = 0;
        if (nbursts[p] >= MAX_BURSTS) return 1'b1;
        left_ticks[p][nbursts[p]] = len;
        nbursts[p]++;
        return 1'b0;
    endfunction

    // one unit of work for the queue head; name of the job, 0 when idle
    function automatic logic [7:0] serve_head(ref int q[$], ref logic pv, ref int pi);
        int p, k;
        if (q.size() == 0) return 8'd0;
        p = q[0];
        k = cur_burst[p];
        if (k >= MAX_BURSTS || k >= nbursts[p]) begin
            void'(q.pop_front());
            return proc_name[p];
        end
        if (left_ticks[p][k] > 0) left_ticks[p][k]--;
        if (left_ticks[p][k] == 0) begin
            cur_burst[p] = k + 1;
            if (cur_burst[p] < nbursts[p]) begin
                pv = 1;
                pi = p;
            end
            void'(q.pop_front());
        end
        return proc_name[p];
    endfunction

    function automatic void enqueue(ref int q[$], input int p);
        if (q.size() < MAX_PROCS) q = {q, p};
    endfunction

    function automatic t_sched_result schedule_item(logic [39:0] d);
        t_sched_result r;
        r = '0;
        case (d[1:0])
            ACT_LOAD:  r.err = store_burst(d);
            ACT_CLEAR: clear_table();
            ACT_TICK: begin
                r.now = tick_now;
                if (!time_over)
                    for (int p = 0; p < nprocs; p++)
                        if (arrive_at[p] == tick_now) enqueue(cpu_q, p);
                if (to_res_v) begin
                    enqueue(res_q, to_res_p);
                    to_res_v = 0;
                end
                if (to_rdy_v) begin
                    enqueue(cpu_q, to_rdy_p);
                    to_rdy_v = 0;
                end
                r.cpu = serve_head(cpu_q, to_res_v, to_res_p);
                r.res = serve_head(res_q, to_rdy_v, to_rdy_p);
                if (tick_now == 16'hFFFF) time_over = 1;
                else tick_now++;
            end
            default: ;
        endcase
        r.done = 1;
        for (int p = 0; p < nprocs; p++)
            if (cur_burst[p] < nbursts[p]) r.done = 0;
        return r;
    endfunction

    assign o_errors = err_count;
    assign o_outstanding = expected_results.size();

    always @(posedge i_clk) begin
        t_sched_result exp_r, got;
        if (!i_rst_n) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results = {expected_results, schedule_item(i_s_tdata)};
            if (i_m_tvalid && i_m_tready) begin
                got = t_sched_result'(i_m_tdata[33:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $realtime, got);
                    err_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.cpu != exp_r.cpu) begin
                        $display("%0t: cpu_process exp %0d got %0d",
                                 $realtime, exp_r.cpu, got.cpu);
                        err_count++;
                    end
                    if (got.res != exp_r.res) begin
                        $display("%0t: resource_process exp %0d got %0d",
                                 $realtime, exp_r.res, got.res);
                        err_count++;
                    end
                    if (got.done != exp_r.done) begin
                        $display("%0t: all_done exp %0b got %0b",
                                 $realtime, exp_r.done, got.done);
                        err_count++;
                    end
                    if (got.err != exp_r.err) begin
                        $display("%0t: load_error exp %0b got %0b",
                                 $realtime, exp_r.err, got.err);
                        err_count++;
                    end
                    if (got.now != exp_r.now) begin
                        $display("%0t: current_time exp %0d got %0d",
                                 $realtime, exp_r.now, got.now);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/fcfs_cpu_and_resource_scheduler_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FCFS scheduler testbench
// Directed loads and ticks for the corner cases, then random process sets
// followed by a run of ticks under varying stream back-pressure. Checking is
// done in the checker module.
// ----------------------------------------------------------------------------
module fcfs_cpu_and_resource_scheduler_top_test;
    import fcfs_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // action, name, arrival, length, last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;        // cpu, resource, all_done, error, time
    int          mismatches, outstanding;
    int          src_idle_pct = 15, snk_idle_pct = 65;
    logic        hold_req = 0;
    logic        hold_done = 0;
    int          items, ticks, loads, sets;
    int          cur_tick;

    always #6 i_clk = ~i_clk;

    fcfs_cpu_and_resource_scheduler_top dut (.*);

    fcfs_scheduler_checker chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_errors(mismatches), .o_outstanding(outstanding)
    );

    // receiver; a hold request stalls it once for a long stretch
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send(input logic [1:0] act, input logic [7:0] nm,
                        input logic [15:0] arr, input logic [7:0] len, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, last, len, arr, nm, act};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items++;
        if (act == ACT_TICK) begin
            ticks++;
            if (cur_tick < 65535) cur_tick++;
        end
        if (act == ACT_LOAD) loads++;
        if (act == ACT_CLEAR) cur_tick = 0;
    endtask

    task automatic tick_n(input int n);
        for (int i = 0; i < n; i++) send(ACT_TICK, '0, '0, '0, 1'b0);
    endtask

    task automatic random_set();
        int np, nb, span;
        logic [15:0] arr;
        logic [7:0]  len;
        logic [7:0]  nm;
        if ($urandom_range(99) < 10) begin
            // noise: anything the fields allow
            repeat ($urandom_range(1, 4))
                send(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                     8'($urandom), 1'($urandom));
            return;
        end
        sets++;
        if ($urandom_range(9) != 0)
            send(ACT_CLEAR, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        np   = $urandom_range(1, 5);
        span = 0;
        for (int p = 0; p < np; p++) begin
            nb  = ($urandom_range(19) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 5);
            nm  = 8'($urandom_range(1, 255));
            arr = ($urandom_range(19) == 0) ? 16'($urandom) :
                                              16'(cur_tick + $urandom_range(0, 8));
            for (int b = 0; b < nb; b++) begin
                case ($urandom_range(39))
                    0:       len = 8'd0;
                    1:       len = 8'd255;
                    2:       len = 8'($urandom_range(128, 200));
                    default: len = 8'($urandom_range(1, 6));
                endcase
                span += (len == 8'd0) ? 1 : int'(len);
                // now and then the closing mark is missing
                send(ACT_LOAD, nm, arr, len,
                     (b == nb - 1) && ($urandom_range(9) != 0));
            end
        end
        tick_n((span > 300 ? 300 : span) + $urandom_range(5, 20));
    endtask

    initial begin
        items = 0; ticks = 0; loads = 0; sets = 0; cur_tick = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // names at both ends, zero length, a full burst list
        send(ACT_LOAD, 8'hFF, 16'd0, 8'd0, 1'b0);
        send(ACT_LOAD, 8'hFF, 16'd0, 8'd3, 1'b0);
        send(ACT_LOAD, 8'hFF, 16'd0, 8'd1, 1'b1);
        for (int b = 0; b < 9; b++)
            send(ACT_LOAD, 8'h01, 16'd1, (b == 4) ? 8'd255 : 8'd2, b == 8);
        tick_n(4);
        send(2'd3, 8'hAA, 16'hFFFF, 8'hFF, 1'b1);   // unused action code
        tick_n(290);
        send(ACT_LOAD, 8'h07, 16'd0, 8'd1, 1'b1);   // arrives in the past
        tick_n(3);
        // bursts appended after the process has started to run
        send(ACT_CLEAR, '0, '0, '0, 1'b0);
        send(ACT_LOAD, 8'h09, 16'd0, 8'd2, 1'b0);
        tick_n(2);
        send(ACT_LOAD, 8'h09, 16'd0, 8'd3, 1'b0);
        tick_n(8);
        send(ACT_LOAD, 8'h09, 16'd0, 8'd1, 1'b1);
        tick_n(3);
        // process table overflow
        send(ACT_CLEAR, '0, '0, '0, 1'b0);
        for (int p = 0; p < 17; p++)
            send(ACT_LOAD, 8'(p + 1), 16'hFFFF, 8'd1, 1'b1);
        send(ACT_LOAD, 8'h80, 16'hFFFF, 8'd1, 1'b0);
        tick_n(2);

        hold_req = 1'b1;
        while (items < 1350) begin
            if (items > 1000) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (items > 600) begin
                src_idle_pct = 65;
                snk_idle_pct = 15;
            end
            random_set();
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Covered %0d transfers: %0d loads, %0d ticks, %0d random process sets,",
                 items, loads, ticks, sets);
        $display("with table and burst overflow, late arrival and a long receiver stall.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
